// ===== hdl/pspip_pkg.sv =====
// Shared types, constants and character codes for the path segment index parser.
`timescale 1ns / 1ps
package pspip_pkg;

	localparam int unsigned INDEX_TEXT_SLOTS = 7;
	localparam int unsigned SLOT_W = $clog2(INDEX_TEXT_SLOTS + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;

	localparam logic [7:0]  SEP_RESET   = 8'd47;
	localparam logic [7:0]  LIMIT_RESET = 8'd64;
	localparam logic [15:0] INDEX_NONE  = 16'hFFFF;
	localparam logic [16:0] ACCUM_SAT   = 17'h10000;

	// Configuration register indexes
	localparam logic REG_SEPARATOR  = 1'b0;
	localparam logic REG_NAME_LIMIT = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_NAME_CHAR = 2'd0;
	localparam logic [1:0] KIND_SEGMENT   = 2'd1;
	localparam logic [1:0] KIND_OVERFLOW  = 2'd2;

	typedef struct packed {
		logic              at_start;
		logic              in_brackets;
		logic [7:0]        name_count;
		logic [SLOT_W-1:0] slots_used;
		logic [16:0]       accum;
		logic              closed;
		logic              digit;
		logic              bad;
		logic              newline;
		logic              discard;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		at_start:    1'b1,
		in_brackets: 1'b0,
		name_count:  8'd0,
		slots_used:  '0,
		accum:       17'd0,
		closed:      1'b0,
		digit:       1'b0,
		bad:         1'b0,
		newline:     1'b0,
		discard:     1'b0
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  name_char;
		logic [7:0]  name_length;
		logic [15:0] index_value;
		logic        path_done;
		logic        truncated;
	} result_t;

endpackage

// ===== hdl/pspip_step.sv =====
// Per-character next-state and result logic of the path segment index parser.
`timescale 1ns / 1ps
module pspip_step (
	input  pspip_pkg::parse_state_t st,
	input  logic [7:0]              ch,
	input  logic [7:0]              separator_char,
	input  logic [7:0]              name_limit,
	output pspip_pkg::parse_state_t nxt,
	output logic                    res_valid,
	output pspip_pkg::result_t      res
);
	import pspip_pkg::*;

	logic [19:0]       times_ten;
	logic [19:0]       accum_sum;
	logic [16:0]       accum_new;
	logic [15:0]       index_now;
	logic [SLOT_W-1:0] slots_next;
	logic              is_nul;
	logic              is_sep;
	logic              is_digit;

	assign is_nul   = (ch == CH_NUL);
	assign is_sep   = (ch == separator_char);
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

	// accum * 10 + digit, saturated just above the 16-bit range
	assign times_ten = {st.accum, 3'b000} + {2'b00, st.accum, 1'b0};
	assign accum_sum = times_ten + {16'd0, ch[3:0]};
	assign accum_new = (accum_sum > {3'b000, ACCUM_SAT}) ? ACCUM_SAT : accum_sum[16:0];

	assign index_now = (!st.digit || st.bad || st.accum[16]) ? INDEX_NONE : st.accum[15:0];
	assign slots_next = st.slots_used + SLOT_W'(1);

	always_comb begin
		nxt       = st;
		res_valid = 1'b0;
		res       = '0;
		if (st.discard) begin
			if (is_nul) begin
				nxt = STATE_RESET;
			end
		end else if (st.at_start && is_sep && !is_nul) begin
			nxt.at_start = 1'b0;
		end else begin
			nxt.at_start = 1'b0;
			if (st.name_count >= name_limit || is_sep || is_nul) begin
				res_valid       = 1'b1;
				res.kind        = KIND_SEGMENT;
				res.name_length = st.name_count;
				res.index_value = index_now;
				res.path_done   = is_nul;
				res.truncated   = (st.name_count >= name_limit);
				nxt             = STATE_RESET;
			end else if (ch == CH_OPEN) begin
				nxt.in_brackets = 1'b1;
			end else if (ch == CH_CLOSE || st.in_brackets) begin
				nxt.slots_used = slots_next;
				if (ch == CH_CLOSE) begin
					nxt.closed      = 1'b1;
					nxt.in_brackets = 1'b0;
				end else if (!st.closed) begin
					if (st.newline) begin
						nxt.bad = 1'b1;
					end else if (ch == CH_PLUS && st.slots_used == '0) begin
						nxt.bad = st.bad;
					end else if (is_digit) begin
						nxt.accum = accum_new;
						nxt.digit = 1'b1;
					end else if (ch == CH_NL) begin
						nxt.newline = 1'b1;
					end else begin
						nxt.bad = 1'b1;
					end
				end
				if (slots_next >= SLOT_W'(INDEX_TEXT_SLOTS)) begin
					res_valid   = 1'b1;
					res.kind    = KIND_OVERFLOW;
					nxt.discard = 1'b1;
				end
			end else begin
				nxt.name_count = st.name_count + 8'd1;
				res_valid      = 1'b1;
				res.kind       = KIND_NAME_CHAR;
				res.name_char  = ch;
			end
		end
	end

endmodule

// ===== hdl/path_segment_index_parser_core.sv =====
// Top level of the path segment index parser: input stage, parse state and result register.
`timescale 1ns / 1ps
//
// Channel   Dir   Payload                                             Handshake
// s_*       in    tdata[7:0] = ch                                     tvalid/tready
// m_*       out   tuser = kind; tdata = name_char, name_length,       tvalid/tready
//                 index_value, path_done, truncated
// cfg_*     in    cfg_addr selects separator_char / name_limit        cfg_we, no wait
//
// One character per cycle while the output does not stall. A request lands in the input
// register, then the combinational parse logic updates the segment state and loads the
// result register, from which a character's result (if any) is shown on the output.
// Reset clears the parse state, the valid flags and loads the default registers.
// A stall at the output holds the result register; the input register still takes
// one more request, and both sides stall only when both are full.
module path_segment_index_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] name_char, [15:8] name_length,
	                               // [31:16] index_value, [32] path_done,
	                               // [33] truncated, [39:34] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_data
);
	import pspip_pkg::*;

	logic [7:0]   separator_q;
	logic [7:0]   limit_q;
	logic         vld_s1;
	logic [7:0]   ch_s1;
	logic         vld_s2;
	result_t      res_s2;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         step_valid;
	result_t      step_res;
	logic         advance;

	// Move the held character through the parse logic whenever the result slot is free
	assign advance  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || advance;

	pspip_step u_step (
		.st             (state_q),
		.ch             (ch_s1),
		.separator_char (separator_q),
		.name_limit     (limit_q),
		.nxt            (state_nxt),
		.res_valid      (step_valid),
		.res            (step_res)
	);

	// Configuration registers; the user must write them only while the block is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= SEP_RESET;
			limit_q     <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SEPARATOR:  separator_q <= cfg_data;
				REG_NAME_LIMIT: limit_q     <= cfg_data;
				default:        separator_q <= separator_q;
			endcase
		end
	end

	// Input stage: take a request whenever the stage empties or is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1 <= s_tdata;
		end
	end

	// Parse state advances once per character consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: load on advance, drop once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= step_valid;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid) begin
			res_s2 <= step_res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {6'd0, res_s2.truncated, res_s2.path_done, res_s2.index_value,
	                   res_s2.name_length, res_s2.name_char};

endmodule

// ===== tb/sv/tb_path_segment_index_parser_core.sv =====
// Self-checking testbench for the path segment index parser core.
`timescale 1ns / 1ps

module tb_path_segment_index_parser_core;

	import pspip_pkg::*;

	// Clock, reset and the block's inputs, all known from time zero
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = 8'd0;
	logic        m_tready = 1'b1;
	logic        cfg_we   = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [7:0]  cfg_data = 8'd0;

	logic        s_tready;
	logic        m_tvalid;
	logic [39:0] m_tdata;   // [7:0] name_char, [15:8] name_length, [31:16] index_value,
	                        // [32] path_done, [33] truncated, [39:34] zero
	logic [1:0]  m_tuser;   // [1:0] kind

	path_segment_index_parser_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	// 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Copy of the parser's registers and segment state, kept in step with every
	// accepted request
	logic [7:0] sep_cfg   = SEP_RESET;
	logic [7:0] limit_cfg = LIMIT_RESET;
	bit         seg_start    = 1'b1;
	bit         bracket_open = 1'b0;
	logic [7:0] name_len     = 8'd0;
	int         slot_cnt     = 0;
	int         idx_acc      = 0;
	bit         f_closed = 1'b0, f_digit = 1'b0, f_bad = 1'b0, f_plus = 1'b0, f_nl = 1'b0;
	bit         skipping = 1'b0;

	result_t parsed_out[$];     // results owed by the block, oldest first
	int      mismatch_count = 0;
	int      sent_count     = 0;
	bit      calm           = 1'b0;   // set: neither side idles

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		$display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got_v, want_v);
		mismatch_count++;
	endtask

	function automatic void clear_segment();
		seg_start    = 1'b1;
		bracket_open = 1'b0;
		name_len     = 8'd0;
		slot_cnt     = 0;
		idx_acc      = 0;
		f_closed     = 1'b0;
		f_digit      = 1'b0;
		f_bad        = 1'b0;
		f_plus       = 1'b0;
		f_nl         = 1'b0;
	endfunction

	// Index text counts only up to the first close bracket; an absent, malformed
	// or too large number reads as "none"
	function automatic logic [15:0] segment_index();
		if (!f_digit || f_bad || idx_acc > 65535)
			return INDEX_NONE;
		return 16'(idx_acc);
	endfunction

	function automatic void add_index_char(input logic [7:0] c);
		if (!f_closed) begin
			if (f_nl) begin
				f_bad = 1'b1;
			end else if (c == CH_PLUS && slot_cnt == 0) begin
				f_plus = 1'b1;
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				idx_acc = idx_acc * 10 + (int'(c) - int'(CH_ZERO));
				if (idx_acc > int'(ACCUM_SAT))
					idx_acc = int'(ACCUM_SAT);
				f_digit = 1'b1;
			end else if (c == CH_NL) begin
				f_nl = 1'b1;
			end else begin
				f_bad = 1'b1;
			end
		end
		slot_cnt++;
	endfunction

	// Advance the parse state by one character; return 1 with the result it causes
	function automatic bit parse_path_char(input logic [7:0] c, output result_t r);
		r = '0;
		if (skipping) begin
			// drop everything up to and including the path terminator
			if (c == CH_NUL) begin
				skipping = 1'b0;
				clear_segment();
			end
			return 1'b0;
		end
		if (seg_start) begin
			seg_start = 1'b0;
			if (c == sep_cfg && c != CH_NUL)
				return 1'b0;
		end
		if (name_len >= limit_cfg) begin
			// name full: this character is dropped and the segment closes truncated
			r.kind        = KIND_SEGMENT;
			r.name_length = name_len;
			r.index_value = segment_index();
			r.path_done   = (c == CH_NUL);
			r.truncated   = 1'b1;
			clear_segment();
			return 1'b1;
		end
		if (c == sep_cfg || c == CH_NUL) begin
			r.kind        = KIND_SEGMENT;
			r.name_length = name_len;
			r.index_value = segment_index();
			r.path_done   = (c == CH_NUL);
			clear_segment();
			return 1'b1;
		end
		if (c == CH_OPEN) begin
			bracket_open = 1'b1;
			return 1'b0;
		end
		if (c == CH_CLOSE) begin
			f_closed = 1'b1;
			slot_cnt++;
			bracket_open = 1'b0;
		end else if (bracket_open) begin
			add_index_char(c);
		end else begin
			name_len++;
			r.kind      = KIND_NAME_CHAR;
			r.name_char = c;
			return 1'b1;
		end
		if (slot_cnt >= INDEX_TEXT_SLOTS) begin
			r.kind   = KIND_OVERFLOW;
			skipping = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 10);
	endfunction

	// Receiver: stall at random, about one time in ten, unless the calm stretch is on
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99) >= 10);

	// Compare each accepted result with the oldest one owed, field by field
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind        = m_tuser;
			got.name_char   = m_tdata[7:0];
			got.name_length = m_tdata[15:8];
			got.index_value = m_tdata[31:16];
			got.path_done   = m_tdata[32];
			got.truncated   = m_tdata[33];
			if (parsed_out.size() == 0) begin
				report_mismatch("result with nothing owed, kind", got.kind, -1);
			end else begin
				want = parsed_out.pop_front();
				if (got.kind !== want.kind)
					report_mismatch("kind", got.kind, want.kind);
				if (got.name_char !== want.name_char)
					report_mismatch("name_char", got.name_char, want.name_char);
				if (got.name_length !== want.name_length)
					report_mismatch("name_length", got.name_length, want.name_length);
				if (got.index_value !== want.index_value)
					report_mismatch("index_value", got.index_value, want.index_value);
				if (got.path_done !== want.path_done)
					report_mismatch("path_done", got.path_done, want.path_done);
				if (got.truncated !== want.truncated)
					report_mismatch("truncated", got.truncated, want.truncated);
			end
		end
	end

	// Offer one character, hold it until the block takes the request, then advance
	// the local parse state. Entered and left just after a rising edge.
	task automatic send_char(input logic [7:0] c);
		result_t r;
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (parse_path_char(c, r))
			parsed_out.push_back(r);
		sent_count++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Drop valid, wait until every owed result has come out, then let the pipeline
	// run empty so that characters without a result are through as well
	task automatic settle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (parsed_out.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (parsed_out.size() != 0) begin
			report_mismatch("results never arrived, count", 0, parsed_out.size());
			parsed_out.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	// Only called while the block is idle
	task automatic write_reg(input logic addr, input logic [7:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (addr == REG_SEPARATOR)
			sep_cfg = val;
		else
			limit_cfg = val;
	endtask

	function automatic logic [7:0] name_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_NUL || b == sep_cfg || b == CH_OPEN || b == CH_CLOSE);
		return b;
	endfunction

	// Bracketed index: optional plus, up to seven digits with the odd stray
	// byte, optional newline, and usually a close bracket
	task automatic send_index();
		int         ndig;
		logic [7:0] odd;
		ndig = $urandom_range(7);
		send_char(CH_OPEN);
		if ($urandom_range(3) == 0)
			send_char(CH_PLUS);
		repeat (ndig) begin
			if ($urandom_range(11) == 0) begin
				case ($urandom_range(2))
					0: begin
						odd = CH_OPEN;
					end
					1: begin
						odd = CH_PLUS;
					end
					default: begin
						odd = 8'($urandom_range(255));
					end
				endcase
				send_char(odd);
			end else begin
				send_char(CH_ZERO + 8'($urandom_range(9)));
			end
		end
		if ($urandom_range(3) == 0)
			send_char(CH_NL);
		if ($urandom_range(7) != 0)
			send_char(CH_CLOSE);
	endtask

	// Mostly well-formed paths with random content; one in ten is a burst of raw
	// bytes, one in eight has no terminator
	task automatic send_path();
		int nseg, nlen, split, s, k;
		bit has_idx;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 12))
				send_char(8'($urandom_range(255)));
			send_char(CH_NUL);
			return;
		end
		nseg = $urandom_range(1, 4);
		for (s = 0; s < nseg; s++) begin
			if ($urandom_range(1))
				send_char(sep_cfg);
			// now and then a name that runs into the limit
			if ($urandom_range(19) == 0)
				nlen = int'(limit_cfg) + int'($urandom_range(2));
			else
				nlen = $urandom_range(6);
			split   = $urandom_range(nlen);
			has_idx = $urandom_range(1);
			for (k = 0; k <= nlen; k++) begin
				if (k == split && has_idx)
					send_index();
				if (k < nlen)
					send_char(name_byte());
			end
			if (s < nseg - 1)
				send_char(sep_cfg);
		end
		if ($urandom_range(7) != 0)
			send_char(CH_NUL);
	endtask

	// Skipped leading separator, extreme name bytes, plus and newline in the index,
	// a segment record and an empty final segment
	task automatic test_basic_path();
		settle();
		send_text("/");
		send_char(8'h01);
		send_char(8'hFF);
		send_text("[+3");
		send_char(CH_NL);
		send_text("]/");
		send_char(CH_NUL);
	endtask

	// Index text filling its slots: overflow, then discard up to the terminator
	task automatic test_index_overflow();
		settle();
		send_text("[123456]zz");
		send_char(CH_NUL);
	endtask

	// Limit zero truncates at once; limit one drops the second character
	task automatic test_name_limit();
		settle();
		write_reg(REG_NAME_LIMIT, 8'd0);
		send_text("q");
		send_char(CH_NUL);
		settle();
		write_reg(REG_NAME_LIMIT, 8'd1);
		send_text("ab");
		send_char(CH_NUL);
		settle();
		write_reg(REG_NAME_LIMIT, LIMIT_RESET);
	endtask

	// Separator equal to an open bracket, then separator equal to the terminator
	task automatic test_separator_cases();
		settle();
		write_reg(REG_SEPARATOR, CH_OPEN);
		send_text("[a[b");
		send_char(CH_NUL);
		settle();
		write_reg(REG_SEPARATOR, CH_NUL);
		send_char(CH_NUL);
		send_text("a");
		send_char(CH_NUL);
		settle();
		write_reg(REG_SEPARATOR, SEP_RESET);
	endtask

	task automatic test_random_paths(input logic [7:0] sep, input logic [7:0] lim,
	                                 input int budget, input bit quiet);
		settle();
		write_reg(REG_SEPARATOR, sep);
		write_reg(REG_NAME_LIMIT, lim);
		calm       = quiet;
		sent_count = 0;
		while (sent_count < budget)
			send_path();
		calm = 1'b0;
	endtask

	initial begin
		// Hold reset once, at the start
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_path();
		test_index_overflow();
		test_name_limit();
		test_separator_cases();

		test_random_paths(SEP_RESET, LIMIT_RESET, 200, 1'b0);
		test_random_paths(8'h2E, 8'd3, 150, 1'b1);
		test_random_paths(CH_CLOSE, 8'd255, 200, 1'b0);
		test_random_paths(CH_OPEN, 8'd1, 100, 1'b0);
		test_random_paths(CH_NUL, 8'd6, 100, 1'b0);
		test_random_paths(8'($urandom_range(255)), 8'($urandom_range(255)), 150, 1'b0);

		settle();
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hard stop far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
